// ===== rtl/core/rgbhsv_pkg.sv =====
`default_nettype none

package rgbhsv_pkg;

  localparam int PixW         = 8;
  localparam int HueW         = 16;
  localparam int SatW         = 16;
  // hue numerator and divisor reach 6 * 255
  localparam int NumW         = PixW + 3;
  localparam int BitsPerStage = 4;
  localparam int NumDivStages = HueW / BitsPerStage;
  localparam int NumStages    = NumDivStages + 1;
  localparam int LastStage    = NumStages - 1;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [NumW-1:0] num_t;

  typedef struct packed {
    pix_t             hi;
    pix_t             sat_rem;
    logic [SatW-1:0]  sat_w;    // dividend bits shift out the top, quotient bits in below
    num_t             hue_rem;
    num_t             hue_div;
    logic [HueW-1:0]  hue_q;
  } stage_t;

  // BitsPerStage restoring division steps on both quotients
  function automatic stage_t div_stage(stage_t s);
    stage_t          o;
    logic [PixW:0]   sr;
    logic [NumW:0]   hr;
    o = s;
    for (int k = 0; k < BitsPerStage; k++) begin
      sr = {o.sat_rem, o.sat_w[SatW-1]};
      o.sat_w = {o.sat_w[SatW-2:0], 1'b0};
      if (sr >= {1'b0, o.hi}) begin
        sr = sr - {1'b0, o.hi};
        o.sat_w[0] = 1'b1;
      end
      o.sat_rem = sr[PixW-1:0];
      hr = {o.hue_rem, 1'b0};
      o.hue_q = {o.hue_q[HueW-2:0], 1'b0};
      if (hr >= {1'b0, o.hue_div}) begin
        hr = hr - {1'b0, o.hue_div};
        o.hue_q[0] = 1'b1;
      end
      o.hue_rem = hr[NumW-1:0];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rgbhsv_pix_if.sv =====
`default_nettype none

interface rgbhsv_pix_if
  import rgbhsv_pkg::*;
();
  logic  valid;
  logic  ready;
  pix_t  red;
  pix_t  green;
  pix_t  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rgbhsv_hsv_if.sv =====
`default_nettype none

interface rgbhsv_hsv_if
  import rgbhsv_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [HueW-1:0]  hue;
  logic [SatW-1:0]  saturation;
  pix_t             brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rgb_to_hsv_convert.sv =====
// RGB to HSV pixel converter.
// pix_i takes one 8-bit red/green/blue pixel per transfer (valid/ready);
// hsv_o gives hue (16-bit turn fraction), saturation (16-bit) and
// brightness (largest channel) for each pixel, in input order.
// Throughput: one pixel per clock while hsv_o is ready.
// Max/min and the hue sector are found in the transfer cycle and
// registered, then four stages each resolve four bits of both
// quotients (hue and saturation) with restoring division steps, and
// the last stage offers the result on hsv_o.
// The whole pipeline moves together: when the result in the last stage
// is not taken, every stage holds and pix_i.ready drops, so nothing is
// lost or repeated. Empty stages never block, so a stalled pipeline with
// bubbles only holds as long as the sink holds.
// Reset clears all valid bits; the block keeps no other state and the
// pipeline is ready as soon as reset is released.
`default_nettype none

module rgb_to_hsv_convert
  import rgbhsv_pkg::*;
(
  input  wire           clk_i,
  input  wire           rst_ni,
  rgbhsv_pix_if.sink    pix_i,
  rgbhsv_hsv_if.source  hsv_o
);

  logic    adv;
  logic    valid_q [NumStages];
  stage_t  pipe_q  [NumStages];
  stage_t  pipe_d  [NumStages];

  pix_t                  r, g, b, hi, lo, d;
  num_t                  d_n, div6, numer;
  logic [PixW+SatW-1:0]  sat_num;

  assign adv         = !valid_q[LastStage] || hsv_o.ready;
  assign pix_i.ready = adv;

  // max, min and hue sector
  always_comb begin
    r = pix_i.red;
    g = pix_i.green;
    b = pix_i.blue;
    hi = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    lo = r;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    d    = hi - lo;
    d_n  = NumW'(d);
    div6 = (d_n << 2) + (d_n << 1);
    if (hi == r) begin
      if (g >= b) numer = NumW'(g) - NumW'(b);
      else        numer = div6 - (NumW'(b) - NumW'(g));
    end else if (hi == g) begin
      numer = (d_n << 1) + NumW'(b) - NumW'(r);
    end else begin
      numer = (d_n << 2) + NumW'(r) - NumW'(g);
    end
    // 65535 * d
    sat_num = {d, SatW'(0)} - (PixW+SatW)'(d);
  end

  always_comb begin
    pipe_d[0].hi      = hi;
    pipe_d[0].sat_rem = sat_num[PixW+SatW-1:SatW];
    pipe_d[0].sat_w   = sat_num[SatW-1:0];
    pipe_d[0].hue_rem = numer;
    pipe_d[0].hue_div = div6;
    pipe_d[0].hue_q   = '0;
    for (int i = 1; i < NumStages; i++) begin
      pipe_d[i] = div_stage(pipe_q[i-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumStages; i++) valid_q[i] <= 1'b0;
    end else if (adv) begin
      valid_q[0] <= pix_i.valid;
      for (int i = 1; i < NumStages; i++) valid_q[i] <= valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < NumStages; i++) pipe_q[i] <= pipe_d[i];
    end
  end

  // grey pixels have a zero hue divisor, black ones a zero value
  assign hsv_o.valid      = valid_q[LastStage];
  assign hsv_o.hue        = (pipe_q[LastStage].hue_div == '0) ? '0 : pipe_q[LastStage].hue_q;
  assign hsv_o.saturation = (pipe_q[LastStage].hi == '0) ? '0 : pipe_q[LastStage].sat_w;
  assign hsv_o.brightness = pipe_q[LastStage].hi;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LastStage] && !hsv_o.ready |-> !pix_i.ready)
    else $error("input taken while result stalled");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> valid_q[0])
    else $error("accepted pixel not in first stage");

  a_hue_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LastStage] && pipe_q[LastStage].hue_div != '0
      |-> pipe_q[LastStage].hue_rem < pipe_q[LastStage].hue_div)
    else $error("hue remainder out of range");

  a_sat_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[LastStage] && pipe_q[LastStage].hi != '0
      |-> pipe_q[LastStage].sat_rem < pipe_q[LastStage].hi)
    else $error("saturation remainder out of range");

  a_grey_hue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid && hsv_o.saturation == '0 |-> hsv_o.hue == '0)
    else $error("grey pixel with nonzero hue");

endmodule

`default_nettype wire
